// ===== rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit allocator package
// Field widths, operation codes, the free mark and the structs that pass
// between the top level and the allocation core.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int DEF_MEM_UNITS = 1024;

	localparam int FUNC_W  = 2;
	localparam int OWNER_W = 8;
	localparam int SIZE_W  = 11;
	localparam int START_W = 10;
	localparam int COUNT_W = 11;

	localparam logic [OWNER_W-1:0] FREE_MARK = 8'hFF;

	localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPACT = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [OWNER_W-1:0] owner;
		logic [SIZE_W-1:0]  size;
	} ffa_cmd_t;

	typedef struct packed {
		logic               ok;
		logic [START_W-1:0] start;
		logic [COUNT_W-1:0] used;
	} ffa_res_t;

endpackage

// ===== rtl/ffa_core.sv =====
// ----------------------------------------------------------------------------
// First-fit allocator core
// Holds the owner map in a synchronous memory and runs request, release and
// compaction as read/modify/write sweeps over it, one unit per cycle.
// ----------------------------------------------------------------------------
module ffa_core
	import ffa_pkg::*;
#(
	parameter int MEM_UNITS = DEF_MEM_UNITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  ffa_cmd_t                     cmd,
	input  logic [$clog2(MEM_UNITS):0]   n_units,
	output logic                         res_valid,
	input  logic                         res_ready,
	output ffa_res_t                     res
);

	localparam int AW = $clog2(MEM_UNITS);
	localparam int CW = AW + 1;
	localparam int XW = (CW > SIZE_W) ? CW : SIZE_W;

	typedef enum logic [4:0] {
		ST_INIT = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_FILL = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t              state_q;
	logic [FUNC_W-1:0]   func_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [SIZE_W-1:0]   size_q;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       limit_q;
	logic [CW-1:0]       rd_addr_q;
	logic                pend_q;
	logic [AW-1:0]       chk_q;
	logic [CW-1:0]       run_q;
	logic [AW-1:0]       base_q;
	logic [CW-1:0]       w_q;
	logic [CW-1:0]       wr_ptr_q;
	logic [CW-1:0]       fill_end_q;
	logic [OWNER_W-1:0]  fill_val_q;
	logic                ok_q;
	logic [AW-1:0]       start_q;
	logic [CW-1:0]       used_q;

	logic [OWNER_W-1:0]  map_mem [MEM_UNITS];
	logic [OWNER_W-1:0]  rd_data_q;

	logic                issue;
	logic                unit_free;
	logic [CW-1:0]       run_n;
	logic [AW-1:0]       base_n;
	logic                hit;
	logic                rel_wr;
	logic                cmp_wr;
	logic                we;
	logic [AW-1:0]       wa;
	logic [OWNER_W-1:0]  wd;
	logic                req_bad;
	logic [XW-1:0]       start_x;
	logic [XW-1:0]       used_x;

	assign issue     = (state_q == ST_SCAN) && (rd_addr_q < limit_q);
	assign unit_free = (rd_data_q == FREE_MARK);
	assign run_n     = unit_free ? run_q + 1'b1 : '0;
	assign base_n    = (run_q == '0) ? chk_q : base_q;
	assign hit       = pend_q && (func_q == FUNC_REQUEST) && unit_free
	                   && (XW'(run_n) >= XW'(size_q));
	assign rel_wr    = (state_q == ST_SCAN) && pend_q && (func_q == FUNC_RELEASE)
	                   && (rd_data_q == owner_q);
	assign cmp_wr    = (state_q == ST_SCAN) && pend_q && (func_q == FUNC_COMPACT)
	                   && !unit_free;
	assign req_bad   = (cmd.owner == FREE_MARK) || (cmd.size == '0)
	                   || (XW'(cmd.size) > XW'(n_units));

	// Single write port. Scan writes always land at or behind the unit whose
	// data is being checked, while reads run ahead, so no forwarding is needed.
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = FREE_MARK;
		priority if (state_q == ST_INIT) begin
			we = 1'b1;
			wa = wr_ptr_q[AW-1:0];
		end else if ((state_q == ST_FILL) && (wr_ptr_q < fill_end_q)) begin
			we = 1'b1;
			wa = wr_ptr_q[AW-1:0];
			wd = fill_val_q;
		end else if (rel_wr) begin
			we = 1'b1;
			wa = chk_q;
		end else if (cmp_wr) begin
			we = 1'b1;
			wa = w_q[AW-1:0];
			wd = rd_data_q;
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			map_mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_q <= map_mem[rd_addr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			func_q     <= FUNC_REQUEST;
			owner_q    <= FREE_MARK;
			size_q     <= '0;
			n_q        <= '0;
			limit_q    <= '0;
			rd_addr_q  <= '0;
			pend_q     <= 1'b0;
			chk_q      <= '0;
			run_q      <= '0;
			base_q     <= '0;
			w_q        <= '0;
			wr_ptr_q   <= '0;
			fill_end_q <= '0;
			fill_val_q <= FREE_MARK;
			ok_q       <= 1'b0;
			start_q    <= '0;
			used_q     <= '0;
		end else begin
			pend_q <= issue;
			if (issue) begin
				rd_addr_q <= rd_addr_q + 1'b1;
				chk_q     <= rd_addr_q[AW-1:0];
			end
			unique case (state_q)
				ST_INIT: begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
					if (wr_ptr_q == CW'(MEM_UNITS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						func_q    <= cmd.func;
						owner_q   <= cmd.owner;
						size_q    <= cmd.size;
						n_q       <= n_units;
						rd_addr_q <= '0;
						run_q     <= '0;
						base_q    <= '0;
						w_q       <= '0;
						start_q   <= '0;
						priority if (cmd.func == FUNC_REQUEST) begin
							ok_q    <= 1'b0;
							limit_q <= n_units;
							state_q <= req_bad ? ST_DONE : ST_SCAN;
						end else if (cmd.func == FUNC_RELEASE) begin
							// Release covers the whole map, not just the region.
							ok_q    <= 1'b1;
							limit_q <= CW'(MEM_UNITS);
							state_q <= (cmd.owner == FREE_MARK) ? ST_DONE : ST_SCAN;
						end else if (cmd.func == FUNC_COMPACT) begin
							ok_q    <= 1'b1;
							limit_q <= n_units;
							state_q <= ST_SCAN;
						end else begin
							ok_q    <= 1'b0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						state_q    <= ST_FILL;
						wr_ptr_q   <= CW'(base_n);
						fill_end_q <= CW'(XW'(base_n) + XW'(size_q));
						fill_val_q <= owner_q;
						ok_q       <= 1'b1;
						start_q    <= base_n;
					end else if (pend_q && (func_q == FUNC_REQUEST)) begin
						run_q  <= run_n;
						base_q <= base_n;
					end
					if (rel_wr) begin
						used_q <= used_q - 1'b1;
					end
					if (cmp_wr) begin
						w_q <= w_q + 1'b1;
					end
					if (!pend_q && !issue) begin
						if (func_q == FUNC_COMPACT) begin
							// Free the tail behind the packed units.
							state_q    <= ST_FILL;
							wr_ptr_q   <= w_q;
							fill_end_q <= n_q;
							fill_val_q <= FREE_MARK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_FILL: begin
					if (wr_ptr_q < fill_end_q) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
					end else begin
						if (func_q == FUNC_REQUEST) begin
							used_q <= used_q + CW'(size_q);
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign start_x   = XW'(start_q);
	assign used_x    = XW'(used_q);
	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res.ok    = ok_q;
	assign res.start = start_x[START_W-1:0];
	assign res.used  = used_x[COUNT_W-1:0];

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(MEM_UNITS))
		else $error("allocated unit count exceeds the map depth");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && we) |-> (wa != rd_addr_q[AW-1:0]))
		else $error("scan write hits the entry being read");

	a_fill_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (fill_end_q <= n_q))
		else $error("fill runs past the active region");

	a_compact_behind: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && (func_q == FUNC_COMPACT) && pend_q)
		|-> (w_q <= CW'(chk_q)))
		else $error("compaction write pointer overtook the read pointer");

	a_start_only_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.start != '0)) |-> (res.ok && (func_q == FUNC_REQUEST)))
		else $error("nonzero start reported without a granted request");

endmodule

// ===== rtl/first_fit_unit_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit unit allocator
// Keeps an owner map of memory units and serves request, release and
// compaction operations with first-fit contiguous placement.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    func, owner, request_size
//  out      output     out_valid / out_ready  ok, start_address, allocated_units
//  cfg      input      cfg_valid / cfg_ready  cfg_data (region_size)
//
// Every operation but a rejected request, a release of the free mark and the
// unused code sweeps the owner map through its single read port, one unit per
// cycle, with writes going back through the single write port. A request scans
// the region until a hole is long enough, then writes the granted run; one that
// finds no hole scans the whole region. A release scans the whole map;
// compaction packs the region's allocated units down, then frees the tail.
// After reset a clearing pass marks every unit free;
// in_ready stays low during it. A result waits in the output register while
// the next transfer is taken; the core stalls only when that register is full.
// ----------------------------------------------------------------------------
module first_fit_unit_allocator
	import ffa_pkg::*;
#(
	parameter int MEM_UNITS = DEF_MEM_UNITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FUNC_W-1:0]  func,
	input  logic [OWNER_W-1:0] owner,
	input  logic [SIZE_W-1:0]  request_size,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               ok,
	output logic [START_W-1:0] start_address,
	output logic [COUNT_W-1:0] allocated_units,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [SIZE_W-1:0]  cfg_data
);

	localparam int AW = $clog2(MEM_UNITS);
	localparam int CW = AW + 1;
	localparam int XW = (CW > SIZE_W) ? CW : SIZE_W;
	localparam logic [SIZE_W-1:0] REGION_RST =
		(MEM_UNITS > 2047) ? {SIZE_W{1'b1}} : SIZE_W'(MEM_UNITS);

	logic [SIZE_W-1:0] region_q;
	logic [CW-1:0]     n_units;
	ffa_cmd_t          cmd;
	ffa_res_t          res;
	logic              res_valid;
	logic              res_ready;
	logic              out_valid_q;
	ffa_res_t          out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= REGION_RST;
		end else if (cfg_valid) begin
			region_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// A region larger than the map acts as the whole map.
	assign n_units = (XW'(region_q) > XW'(MEM_UNITS)) ? CW'(MEM_UNITS)
	                                                  : CW'(XW'(region_q));

	assign cmd.func  = func;
	assign cmd.owner = owner;
	assign cmd.size  = request_size;

	ffa_core #(
		.MEM_UNITS (MEM_UNITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (in_valid),
		.cmd_ready (in_ready),
		.cmd       (cmd),
		.n_units   (n_units),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign ok              = out_q.ok;
	assign start_address   = out_q.start;
	assign allocated_units = out_q.used;

endmodule

// ===== tb/sv/first_fit_unit_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit unit allocator testbench
// Drives request, release and compaction transfers into the allocator under
// several region sizes and random idling on both channels. A local owner map
// predicts every result, which is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module first_fit_unit_allocator_test;
	import ffa_pkg::*;

	localparam int MEM_UNITS      = DEF_MEM_UNITS;
	localparam int TIMEOUT_CYCLES = 3_000_000;
	localparam int SETTLE_CYCLES  = 2 * MEM_UNITS + 64;

	// The block reports func 3 as a failed no-op.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [FUNC_W-1:0]  func;
	logic [OWNER_W-1:0] owner;
	logic [SIZE_W-1:0]  request_size;
	logic               out_valid;
	logic               out_ready;
	logic               ok;
	logic [START_W-1:0] start_address;
	logic [COUNT_W-1:0] allocated_units;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [SIZE_W-1:0]  cfg_data;

	// Predicted state of the block.
	logic [OWNER_W-1:0] unit_owner [MEM_UNITS];
	int                 owned_units;
	logic [SIZE_W-1:0]  region_units;

	ffa_res_t pending_results [$];
	int       error_count;
	int       cycle_count;
	int       hold_cycles;
	int       stall_left;
	bit       sender_gaps;
	bit       receiver_stalls;
	bit       offering;

	first_fit_unit_allocator #(
		.MEM_UNITS(MEM_UNITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.owner(owner),
		.request_size(request_size),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ok(ok),
		.start_address(start_address),
		.allocated_units(allocated_units),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < TIMEOUT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL first_fit_unit_allocator");
		$finish;
	end

	// Result side: random stall bursts, plus a long hold-off on request.
	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(1, 10) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		ffa_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: ok %0d start_address %0d allocated_units %0d",
					ok, start_address, allocated_units);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (ok !== want.ok) begin
					$error("ok: expected %0d, actual %0d", want.ok, ok);
					error_count++;
				end
				if (start_address !== want.start) begin
					$error("start_address: expected %0d, actual %0d", want.start,
						start_address);
					error_count++;
				end
				if (allocated_units !== want.used) begin
					$error("allocated_units: expected %0d, actual %0d", want.used,
						allocated_units);
					error_count++;
				end
			end
		end
	end

	function automatic ffa_res_t allocation_outcome(input ffa_cmd_t c);
		ffa_res_t r;
		int       span;
		int       run;
		int       base;
		int       w;
		int       i;
		int       k;
		bit       placed;
		r = '0;
		span = (region_units > MEM_UNITS) ? MEM_UNITS : region_units;
		case (c.func)
			FUNC_REQUEST: begin
				if (c.owner != FREE_MARK && c.size != 0 && c.size <= span) begin
					run = 0;
					base = 0;
					placed = 1'b0;
					for (i = 0; i < span && !placed; i++) begin
						if (unit_owner[i] == FREE_MARK) begin
							if (run == 0)
								base = i;
							run++;
							if (run >= c.size) begin
								for (k = base; k < base + c.size; k++)
									unit_owner[k] = c.owner;
								owned_units += c.size;
								r.ok = 1'b1;
								r.start = base[START_W-1:0];
								placed = 1'b1;
							end
						end else begin
							run = 0;
						end
					end
				end
			end
			FUNC_RELEASE: begin
				// A release reaches the whole map, not just the active region.
				if (c.owner != FREE_MARK) begin
					for (i = 0; i < MEM_UNITS; i++) begin
						if (unit_owner[i] == c.owner) begin
							unit_owner[i] = FREE_MARK;
							owned_units--;
						end
					end
				end
				r.ok = 1'b1;
			end
			FUNC_COMPACT: begin
				w = 0;
				for (i = 0; i < span; i++) begin
					if (unit_owner[i] != FREE_MARK) begin
						unit_owner[w] = unit_owner[i];
						w++;
					end
				end
				while (w < span) begin
					unit_owner[w] = FREE_MARK;
					w++;
				end
				r.ok = 1'b1;
			end
			default: begin
			end
		endcase
		r.used = owned_units[COUNT_W-1:0];
		return r;
	endfunction

	function automatic ffa_cmd_t make_op(input logic [FUNC_W-1:0] f,
			input logic [OWNER_W-1:0] o, input logic [SIZE_W-1:0] s);
		ffa_cmd_t c;
		c.func = f;
		c.owner = o;
		c.size = s;
		return c;
	endfunction

	function automatic ffa_cmd_t random_op();
		ffa_cmd_t c;
		int       span;
		int       cap;
		int       pick;
		span = (region_units > MEM_UNITS) ? MEM_UNITS : region_units;
		if (span == 0)
			span = 4;
		cap = (span / 8 > 1) ? span / 8 : 1;
		// A small owner pool keeps releases hitting live allocations.
		pick = $urandom_range(0, 99);
		if (pick < 80)
			c.owner = OWNER_W'($urandom_range(0, 11));
		else if (pick < 95)
			c.owner = OWNER_W'($urandom_range(0, 254));
		else
			c.owner = FREE_MARK;
		c.size = SIZE_W'($urandom_range(0, 2047));
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			c.func = FUNC_REQUEST;
			pick = $urandom_range(0, 99);
			if (pick < 60)
				c.size = SIZE_W'($urandom_range(1, cap));
			else if (pick < 80)
				c.size = SIZE_W'($urandom_range(1, span));
			else if (pick < 90)
				c.size = SIZE_W'($urandom_range(0, 2047));
			else begin
				case ($urandom_range(0, 2))
					0: c.size = '0;
					1: c.size = SIZE_W'(span);
					default: c.size = SIZE_W'(span + 1);
				endcase
			end
		end else if (pick < 80) begin
			c.func = FUNC_RELEASE;
		end else if (pick < 95) begin
			c.func = FUNC_COMPACT;
		end else begin
			c.func = FUNC_UNUSED;
		end
		return c;
	endfunction

	task automatic send_item(input ffa_cmd_t c);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			if (offering) begin
				in_valid <= 1'b0;
				offering = 1'b0;
			end
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		offering = 1'b1;
		func <= c.func;
		owner <= c.owner;
		request_size <= c.size;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(allocation_outcome(c));
	endtask

	task automatic wait_drained();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_region(input logic [SIZE_W-1:0] units);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= units;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		region_units = units;
	endtask

	task automatic test_directed_ops();
		write_region(SIZE_W'(MEM_UNITS));
		send_item(make_op(FUNC_REQUEST, 8'd0, 11'd0));
		send_item(make_op(FUNC_REQUEST, FREE_MARK, 11'd4));
		send_item(make_op(FUNC_REQUEST, 8'd1, 11'd1025));
		send_item(make_op(FUNC_REQUEST, 8'd1, 11'd2047));
		send_item(make_op(FUNC_REQUEST, 8'd0, 11'd1));
		send_item(make_op(FUNC_REQUEST, 8'd2, 11'd100));
		send_item(make_op(FUNC_REQUEST, 8'd3, 11'd50));
		send_item(make_op(FUNC_RELEASE, 8'd2, 11'd0));
		// The hole left by owner 2 takes 60 but is then too short for 50.
		send_item(make_op(FUNC_REQUEST, 8'd4, 11'd60));
		send_item(make_op(FUNC_REQUEST, 8'd5, 11'd50));
		send_item(make_op(FUNC_RELEASE, FREE_MARK, 11'd2047));
		send_item(make_op(FUNC_COMPACT, 8'd0, 11'd0));
		send_item(make_op(FUNC_REQUEST, 8'd254, 11'd863));
		send_item(make_op(FUNC_REQUEST, 8'd6, 11'd1));
		send_item(make_op(FUNC_UNUSED, FREE_MARK, 11'd2047));
		send_item(make_op(FUNC_RELEASE, 8'd254, 11'd0));
		send_item(make_op(FUNC_RELEASE, 8'd0, 11'd0));
		send_item(make_op(FUNC_COMPACT, 8'd0, 11'd0));
		send_item(make_op(FUNC_RELEASE, 8'd3, 11'd0));
		send_item(make_op(FUNC_RELEASE, 8'd4, 11'd0));
		send_item(make_op(FUNC_RELEASE, 8'd5, 11'd0));
		send_item(make_op(FUNC_REQUEST, 8'd170, 11'd1024));
		send_item(make_op(FUNC_RELEASE, 8'd170, 11'd0));
	endtask

	task automatic test_region_limits();
		send_item(make_op(FUNC_REQUEST, 8'd10, 11'd4));
		send_item(make_op(FUNC_REQUEST, 8'd11, 11'd8));
		send_item(make_op(FUNC_REQUEST, 8'd13, 11'd900));
		send_item(make_op(FUNC_RELEASE, 8'd11, 11'd0));
		// Shrunk region: compaction stays below it, a release still reaches beyond.
		write_region(11'd8);
		send_item(make_op(FUNC_COMPACT, 8'd0, 11'd0));
		send_item(make_op(FUNC_REQUEST, 8'd14, 11'd9));
		send_item(make_op(FUNC_RELEASE, 8'd13, 11'd0));
		write_region(11'd0);
		send_item(make_op(FUNC_REQUEST, 8'd15, 11'd1));
		send_item(make_op(FUNC_COMPACT, 8'd0, 11'd0));
		write_region(11'd2047);
		send_item(make_op(FUNC_REQUEST, 8'd16, 11'd1024));
		send_item(make_op(FUNC_REQUEST, 8'd16, 11'd64));
		write_region(11'd1);
		send_item(make_op(FUNC_REQUEST, 8'd17, 11'd1));
		send_item(make_op(FUNC_RELEASE, 8'd10, 11'd0));
		send_item(make_op(FUNC_REQUEST, 8'd17, 11'd1));
		send_item(make_op(FUNC_RELEASE, 8'd16, 11'd0));
	endtask

	// Hold the result side long enough that the block backs up into its input.
	task automatic test_stall_fill();
		int n;
		write_region(11'd16);
		sender_gaps = 1'b0;
		hold_cycles = 600;
		for (n = 0; n < 12; n++)
			send_item(make_op(FUNC_REQUEST, 8'd20, 11'($urandom_range(1, 3))));
		wait_drained();
		sender_gaps = 1'b1;
	endtask

	// Each phase drains completely before the region changes.
	task automatic test_random_mix();
		logic [SIZE_W-1:0] phase_region [9];
		int p;
		int n;
		phase_region = '{11'd64, 11'd1024, 11'd16, 11'd2047, 11'd1, 11'd300, 11'd0,
			11'd8, 11'd1024};
		for (p = 0; p < 9; p++) begin
			write_region(phase_region[p]);
			for (n = 0; n < 24; n++)
				send_item(random_op());
		end
	endtask

	task automatic test_quiet_tail();
		int n;
		write_region(11'd128);
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		for (n = 0; n < 24; n++)
			send_item(random_op());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_REQUEST;
		owner = '0;
		request_size = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		error_count = 0;
		hold_cycles = 0;
		offering = 1'b0;
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		for (int i = 0; i < MEM_UNITS; i++)
			unit_owner[i] = FREE_MARK;
		owned_units = 0;
		region_units = SIZE_W'(MEM_UNITS);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_ops();
		test_region_limits();
		test_stall_fill();
		test_random_mix();
		test_quiet_tail();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS first_fit_unit_allocator");
		else
			$display("FAIL first_fit_unit_allocator");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ffa_pkg.sv
rtl/ffa_core.sv
rtl/first_fit_unit_allocator.sv
tb/sv/first_fit_unit_allocator_test.sv
